### rtl/assert_macros.svh
// assertion macros shared by the checker files
// every macro samples on clk_i and is disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

### rtl/dfc_pkg.sv
// types, codes and constants of the diagnostic frame classifier
// used by dfc_front, dfc_fifo, dfc_back, the top level and the checker
`timescale 1ns / 1ps

package dfc_pkg;

  localparam int unsigned NUM_PAT     = 11;
  localparam int unsigned FLAG_W      = NUM_PAT + 1;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // request modes
  localparam logic [1:0] MODE_FRAME = 2'd0;
  localparam logic [1:0] MODE_WAIT  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // identifier fields
  localparam logic [4:0] ID_PRIO   = 5'h18;
  localparam logic [7:0] PF_CLAIM  = 8'hEE;
  localparam logic [7:0] PS_GLOBAL = 8'hFF;
  localparam logic [7:0] SA_NULL   = 8'hFE;
  localparam logic [7:0] PF_DM1    = 8'hFE;
  localparam logic [7:0] PS_DM1    = 8'hCA;
  localparam logic [7:0] PF_DM15   = 8'hD8;
  localparam logic [7:0] PF_DM16   = 8'hD7;

  // dm15 status field codes
  localparam logic [3:0] DM15_CODE_PROCEED   = 4'd0;
  localparam logic [3:0] DM15_CODE_BUSY      = 4'd1;
  localparam logic [3:0] DM15_CODE_COMPLETED = 4'd4;
  localparam logic [3:0] DM15_CODE_FAILED    = 4'd5;

  typedef enum logic [2:0] {
    KIND_IGNORED = 3'd0,
    KIND_CLAIM   = 3'd1,
    KIND_NOCLAIM = 3'd2,
    KIND_FAULT   = 3'd3,
    KIND_STATUS  = 3'd4,
    KIND_DATA    = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_WAITING   = 3'd0,
    ST_PROCEED   = 3'd1,
    ST_BUSY      = 3'd2,
    ST_COMPLETED = 3'd3,
    ST_FAILED    = 3'd4,
    ST_FAULT     = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_WAIT,
    OP_CLEAR,
    OP_CLAIM,
    OP_FAULT,
    OP_STATUS,
    OP_DATA
  } op_e;

  // dm1 pattern: byte 2, byte 3, top three bits of byte 4, fmi
  typedef struct packed {
    logic [7:0] b2;
    logic [7:0] b3;
    logic [2:0] spn;
    logic [4:0] fmi;
  } fault_pat_t;

  localparam fault_pat_t FAULT_PAT [NUM_PAT] = '{
    '{8'h3F, 8'hF0, 3'd7, 5'h13},
    '{8'h3F, 8'hF0, 3'd7, 5'h09},
    '{8'h74, 8'h02, 3'd0, 5'h02},
    '{8'h40, 8'hF0, 3'd7, 5'h00},
    '{8'h9E, 8'h00, 3'd0, 5'h12},
    '{8'h9E, 8'h00, 3'd0, 5'h10},
    '{8'h42, 8'hF0, 3'd7, 5'h00},
    '{8'h42, 8'hF0, 3'd7, 5'h01},
    '{8'h44, 8'hF0, 3'd7, 5'h00},
    '{8'h43, 8'hF0, 3'd7, 5'h02},
    '{8'h76, 8'h02, 3'd0, 5'h02}
  };

  // decoded request, front to back
  typedef struct packed {
    op_e                op;
    logic [7:0]         src;
    logic               noclaim;
    logic [FLAG_W-1:0]  flag_set;
    logic               stat_upd;
    status_e            stat_val;
    logic [63:0]        data;
  } cmd_t;

  // result as it leaves the back part
  typedef struct packed {
    kind_e              kind;
    logic [7:0]         peer_address;
    logic [63:0]        peer_name;
    logic [FLAG_W-1:0]  fault_flags;
    status_e            access_status;
    logic [63:0]        memory_data;
  } res_t;

endpackage

### rtl/dfc_front.sv
// front part: holds own_address and decodes each request into a cmd_t
// depends on dfc_pkg
`timescale 1ns / 1ps

module dfc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_wdata_i,
  input  logic [1:0]    mode_i,
  input  logic [28:0]   frame_id_i,
  input  logic [63:0]   frame_data_i,
  output dfc_pkg::cmd_t cmd_o
);
  import dfc_pkg::*;

  logic [7:0] own_addr_q;
  logic [4:0] i0;
  logic [7:0] i1, i2, i3;
  logic [7:0] b2, b3, b4;
  logic [3:0] dm15_code;
  logic [NUM_PAT-1:0] pat_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= 8'h00;
    end else if (cfg_we_i) begin
      own_addr_q <= cfg_wdata_i;
    end
  end

  assign i0 = frame_id_i[28:24];
  assign i1 = frame_id_i[23:16];
  assign i2 = frame_id_i[15:8];
  assign i3 = frame_id_i[7:0];
  assign b2 = frame_data_i[23:16];
  assign b3 = frame_data_i[31:24];
  assign b4 = frame_data_i[39:32];
  assign dm15_code = frame_data_i[12:9];

  // patterns are distinct, so at most one hits
  for (genvar g = 0; g < NUM_PAT; g++) begin : g_pat
    assign pat_hit[g] = (b2 == FAULT_PAT[g].b2) && (b3 == FAULT_PAT[g].b3) &&
                        (b4[7:5] == FAULT_PAT[g].spn) && (b4[4:0] == FAULT_PAT[g].fmi);
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.op       = OP_NONE;
    cmd_o.src      = i3;
    cmd_o.noclaim  = (i3 == SA_NULL);
    cmd_o.flag_set = {pat_hit, 1'b0};
    cmd_o.stat_upd = 1'b0;
    cmd_o.stat_val = ST_PROCEED;
    cmd_o.data     = frame_data_i;

    unique case (dm15_code)
      DM15_CODE_PROCEED: begin
        cmd_o.stat_upd = 1'b1;
        cmd_o.stat_val = ST_PROCEED;
      end
      DM15_CODE_BUSY: begin
        cmd_o.stat_upd = 1'b1;
        cmd_o.stat_val = ST_BUSY;
      end
      DM15_CODE_COMPLETED: begin
        cmd_o.stat_upd = 1'b1;
        cmd_o.stat_val = ST_COMPLETED;
      end
      DM15_CODE_FAILED: begin
        cmd_o.stat_upd = 1'b1;
        cmd_o.stat_val = ST_FAILED;
      end
      default: begin
        cmd_o.stat_upd = 1'b0;
      end
    endcase

    unique case (mode_i)
      MODE_FRAME: begin
        // source address against the peer is checked in the back part
        if (i0 == ID_PRIO) begin
          priority if (i1 == PF_CLAIM && i2 == PS_GLOBAL) begin
            cmd_o.op = OP_CLAIM;
          end else if (i1 == PF_DM1 && i2 == PS_DM1) begin
            cmd_o.op = OP_FAULT;
          end else if (i1 == PF_DM15 && i2 == own_addr_q) begin
            cmd_o.op = OP_STATUS;
          end else if (i1 == PF_DM16 && i2 == own_addr_q) begin
            cmd_o.op = OP_DATA;
          end else begin
            cmd_o.op = OP_NONE;
          end
        end
      end
      MODE_WAIT:  cmd_o.op = OP_WAIT;
      MODE_CLEAR: cmd_o.op = OP_CLEAR;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

endmodule

### rtl/dfc_fifo.sv
// short queue of decoded requests between front and back
// depends on dfc_pkg
`timescale 1ns / 1ps

module dfc_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dfc_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output dfc_pkg::cmd_t data_o
);
  import dfc_pkg::*;

  cmd_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]   count_q, count_d;

  assign full_o  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/dfc_back.sv
// back part: diagnostic state, applies each decoded request, holds the result
// depends on dfc_pkg
`timescale 1ns / 1ps

module dfc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  dfc_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output dfc_pkg::res_t res_o
);
  import dfc_pkg::*;

  logic              valid_q, valid_d;
  kind_e             kind_q, kind_d;
  logic [7:0]        addr_q, addr_d;
  logic [63:0]       name_q, name_d;
  logic [FLAG_W-1:0] flags_q, flags_d;
  status_e           status_q, status_d;
  logic [63:0]       mem_q, mem_d;
  logic              from_peer;

  // state changes only on a pop, so the held result reads the live state
  assign cmd_pop_o = cmd_valid_i && (!valid_q || res_ready_i);
  assign from_peer = (cmd_i.src == addr_q);

  always_comb begin
    valid_d  = valid_q && !res_ready_i;
    kind_d   = kind_q;
    addr_d   = addr_q;
    name_d   = name_q;
    flags_d  = flags_q;
    status_d = status_q;
    mem_d    = mem_q;
    if (cmd_pop_o) begin
      valid_d = 1'b1;
      kind_d  = KIND_IGNORED;
      unique case (cmd_i.op)
        OP_WAIT:  status_d = ST_WAITING;
        OP_CLEAR: mem_d = '0;
        OP_CLAIM: begin
          name_d = cmd_i.data;
          if (cmd_i.noclaim) begin
            addr_d  = 8'h00;
            flags_d = flags_q | FLAG_W'(1);
            kind_d  = KIND_NOCLAIM;
          end else begin
            addr_d = cmd_i.src;
            kind_d = KIND_CLAIM;
          end
        end
        OP_FAULT: begin
          if (from_peer) begin
            kind_d = KIND_FAULT;
            if (cmd_i.flag_set != '0) begin
              flags_d  = flags_q | cmd_i.flag_set;
              status_d = ST_FAULT;
            end
          end
        end
        OP_STATUS: begin
          if (from_peer) begin
            kind_d = KIND_STATUS;
            if (cmd_i.stat_upd) begin
              status_d = cmd_i.stat_val;
            end
          end
        end
        OP_DATA: begin
          if (from_peer) begin
            kind_d = KIND_DATA;
            mem_d  = cmd_i.data;
          end
        end
        default: kind_d = KIND_IGNORED;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      kind_q   <= KIND_IGNORED;
      addr_q   <= 8'h00;
      name_q   <= '0;
      flags_q  <= '0;
      status_q <= ST_PROCEED;
      mem_q    <= '0;
    end else begin
      valid_q  <= valid_d;
      kind_q   <= kind_d;
      addr_q   <= addr_d;
      name_q   <= name_d;
      flags_q  <= flags_d;
      status_q <= status_d;
      mem_q    <= mem_d;
    end
  end

  assign res_valid_o         = valid_q;
  assign res_o.kind          = kind_q;
  assign res_o.peer_address  = addr_q;
  assign res_o.peer_name     = name_q;
  assign res_o.fault_flags   = flags_q;
  assign res_o.access_status = status_q;
  assign res_o.memory_data   = mem_q;

endmodule

### rtl/diagnostic_frame_classifier.sv
// channel   dir  tdata                                   tuser
// s_axis    in   frame_id, frame_data (96 bits)          mode
// m_axis    out  peer_address .. memory_data (152 bits)  frame_kind
// cfg       in   own_address (write enable + data)       -
//
// one request per cycle sustained while m_axis_tready stays high; a request goes
// from front decode into a two-entry queue, then the back part updates state
// and registers the result. the back part and its result register set the rate.
// rst_ni clears the queue, the result register and all diagnostic state
// (status resets to proceed). a stalled output backs up into the queue, and
// s_axis_tready drops once the queue is full.
// depends on dfc_pkg, dfc_front, dfc_fifo, dfc_back
`timescale 1ns / 1ps

module diagnostic_frame_classifier (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [7:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // frame_id[28:0], frame_data[92:29], zero pad
  input  logic [1:0]   s_axis_tuser,   // mode[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [151:0] m_axis_tdata,   // peer_address[7:0], peer_name[71:8],
                                       // fault_flags[83:72], access_status[86:84],
                                       // memory_data[150:87], zero pad
  output logic [2:0]   m_axis_tuser    // frame_kind[2:0]
);
  import dfc_pkg::*;

  cmd_t front_cmd, queue_cmd;
  res_t res;
  logic queue_full, queue_valid, queue_pop, push;

  assign s_axis_tready = !queue_full;
  assign push          = s_axis_tvalid && s_axis_tready;

  dfc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mode_i      (s_axis_tuser),
    .frame_id_i  (s_axis_tdata[28:0]),
    .frame_data_i(s_axis_tdata[92:29]),
    .cmd_o       (front_cmd)
  );

  dfc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_cmd),
    .full_o (queue_full),
    .pop_i  (queue_pop),
    .valid_o(queue_valid),
    .data_o (queue_cmd)
  );

  dfc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(queue_valid),
    .cmd_i      (queue_cmd),
    .cmd_pop_o  (queue_pop),
    .res_valid_o(m_axis_tvalid),
    .res_ready_i(m_axis_tready),
    .res_o      (res)
  );

  assign m_axis_tuser = res.kind;
  assign m_axis_tdata = {1'b0, res.memory_data, res.access_status, res.fault_flags,
                         res.peer_name, res.peer_address};

endmodule

### rtl/dfc_checker.sv
// port-level checks for diagnostic_frame_classifier, bound to the top level
// depends on dfc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dfc_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [151:0] m_axis_tdata,
  input logic [2:0]   m_axis_tuser
);
  import dfc_pkg::*;

  `ASSERT_CLK(a_out_valid_holds, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid,
              "result dropped while stalled")
  `ASSERT_CLK(a_out_payload_holds,
              m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser),
              "result changed while stalled")
  // fault flags are sticky
  `ASSERT_CLK(a_flags_sticky, ($past(m_axis_tdata[83:72]) & ~m_axis_tdata[83:72]) == 12'h000,
              "fault flag cleared")
  `ASSERT_NEVER(a_noclaim_state,
                m_axis_tvalid && m_axis_tuser == KIND_NOCLAIM &&
                (m_axis_tdata[7:0] != 8'h00 || !m_axis_tdata[72]),
                "cannot-claim result without zero address and flag 0")
  `ASSERT_NEVER(a_claim_addr,
                m_axis_tvalid && m_axis_tuser == KIND_CLAIM && m_axis_tdata[7:0] == SA_NULL,
                "claim result shows the null address")

endmodule

bind diagnostic_frame_classifier dfc_checker u_dfc_checker (.*);

### tb/diagnostic_frame_classifier_test.sv
// self-checking bench for the diagnostic frame classifier top level
// predicts every result from its own copy of the diagnostic state
// depends on dfc_pkg and diagnostic_frame_classifier
`timescale 1ns / 1ps

module diagnostic_frame_classifier_test;
  import dfc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned PHASE_ITEMS = 144;
  localparam int unsigned NUM_PHASES  = 8;
  // mode code with no meaning
  localparam logic [1:0]  MODE_UNUSED = 2'd3;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  peer_address;
    logic [63:0] peer_name;
    logic [11:0] fault_flags;
    status_e     access_status;
    logic [63:0] memory_data;
  } frame_result_t;

  class classifier_scoreboard;
    logic [7:0]    own_addr;
    logic [7:0]    peer_addr;
    logic [63:0]   peer_name;
    logic [11:0]   flags;
    status_e       status;
    logic [63:0]   mem_data;
    frame_result_t pending_results[$];
    int            errors;
    int            requests;
    int            checked;
    int            kind_hits[6];

    function void clear_state();
      own_addr  = '0;
      peer_addr = '0;
      peer_name = '0;
      flags     = '0;
      status    = ST_PROCEED;
      mem_data  = '0;
    endfunction

    // {byte 2, byte 3, byte 4} of each dm1 fault pattern, byte 4 = {spn, fmi}
    static function logic [23:0] fault_pattern(int i);
      case (i)
        0:       return 24'h3FF0F3;
        1:       return 24'h3FF0E9;
        2:       return 24'h740202;
        3:       return 24'h40F0E0;
        4:       return 24'h9E0012;
        5:       return 24'h9E0010;
        6:       return 24'h42F0E0;
        7:       return 24'h42F0E1;
        8:       return 24'h44F0E0;
        9:       return 24'h43F0E2;
        default: return 24'h760202;
      endcase
    endfunction

    function void predict_request(logic [1:0] mode, logic [28:0] id, logic [63:0] d);
      kind_e         kind;
      frame_result_t res;
      logic [4:0]    pri;
      logic [7:0]    pf;
      logic [7:0]    ps;
      logic [7:0]    sa;
      pri  = id[28:24];
      pf   = id[23:16];
      ps   = id[15:8];
      sa   = id[7:0];
      kind = KIND_IGNORED;
      if (mode == MODE_WAIT) begin
        status = ST_WAITING;
      end else if (mode == MODE_CLEAR) begin
        mem_data = '0;
      end else if (mode == MODE_FRAME && pri == ID_PRIO) begin
        if (pf == PF_CLAIM && ps == PS_GLOBAL) begin
          peer_name = d;
          if (sa != SA_NULL) begin
            peer_addr = sa;
            kind      = KIND_CLAIM;
          end else begin
            peer_addr = '0;
            flags[0]  = 1'b1;
            kind      = KIND_NOCLAIM;
          end
        end else if (pf == PF_DM1 && ps == PS_DM1 && sa == peer_addr) begin
          kind = KIND_FAULT;
          // first matching pattern wins
          for (int i = 0; i < 11; i++) begin
            if ({d[23:16], d[31:24], d[39:32]} == fault_pattern(i)) begin
              flags[i+1] = 1'b1;
              status     = ST_FAULT;
              break;
            end
          end
        end else if (pf == PF_DM15 && ps == own_addr && sa == peer_addr) begin
          kind = KIND_STATUS;
          case (d[12:9])
            DM15_CODE_PROCEED:   status = ST_PROCEED;
            DM15_CODE_BUSY:      status = ST_BUSY;
            DM15_CODE_COMPLETED: status = ST_COMPLETED;
            DM15_CODE_FAILED:    status = ST_FAILED;
            default: ;
          endcase
        end else if (pf == PF_DM16 && ps == own_addr && sa == peer_addr) begin
          kind     = KIND_DATA;
          mem_data = d;
        end
      end
      res.kind          = kind;
      res.peer_address  = peer_addr;
      res.peer_name     = peer_name;
      res.fault_flags   = flags;
      res.access_status = status;
      res.memory_data   = mem_data;
      pending_results.push_back(res);
      requests++;
    endfunction

    function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [2:0] kind, logic [151:0] data);
      frame_result_t res;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, kind %h data %h", $time, kind, data);
        errors++;
        return;
      end
      res = pending_results.pop_front();
      checked++;
      if (res.kind < 6) kind_hits[res.kind]++;
      compare_field("frame_kind", 64'(res.kind), 64'(kind));
      compare_field("peer_address", 64'(res.peer_address), 64'(data[7:0]));
      compare_field("peer_name", res.peer_name, data[71:8]);
      compare_field("fault_flags", 64'(res.fault_flags), 64'(data[83:72]));
      compare_field("access_status", 64'(res.access_status), 64'(data[86:84]));
      compare_field("memory_data", res.memory_data, data[150:87]);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [7:0]   cfg_wdata_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [151:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;

  classifier_scoreboard sb = new;
  logic        calm;
  int unsigned cycles;
  int          own_writes;

  diagnostic_frame_classifier uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] with_pattern(logic [63:0] d, logic [23:0] pat);
    logic [63:0] v;
    v        = d;
    v[23:16] = pat[23:16];
    v[31:24] = pat[15:8];
    v[39:32] = pat[7:0];
    return v;
  endfunction

  // receiver: bursts of ready with random stalls in between
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    forever begin
      stall = calm ? 0 : idle_len();
      repeat (stall) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      repeat ($urandom_range(1, 16)) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_request(input logic [1:0] mode, input logic [28:0] id,
                              input logic [63:0] d);
    int gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {32'(0), rand64()};
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, d, id};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.predict_request(mode, id, d);
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    // two-stage pipe, every request yields a result; then a short extra wait for margin
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_own_address(input logic [7:0] a);
    wait_drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= a;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.own_addr = a;
    own_writes++;
  endtask

  task automatic random_request();
    int          r;
    int          c;
    logic [1:0]  mode;
    logic [28:0] id;
    logic [63:0] d;
    logic [23:0] pat;
    logic [7:0]  sa;
    logic [7:0]  pf;
    logic [7:0]  ps;
    r    = $urandom_range(0, 99);
    mode = MODE_FRAME;
    d    = rand64();
    id   = 29'($urandom);
    if (r < 12) begin
      c  = $urandom_range(0, 7);
      sa = (c == 0) ? SA_NULL : (c == 1) ? 8'h00 : (c == 2) ? 8'hFF : 8'($urandom);
      id = {ID_PRIO, PF_CLAIM, PS_GLOBAL, sa};
    end else if (r < 32) begin
      c = $urandom_range(0, 99);
      if (c < 60) begin
        d = with_pattern(d, classifier_scoreboard::fault_pattern($urandom_range(0, 10)));
      end else if (c < 75) begin
        d = with_pattern(d, 24'h000000);
      end else if (c < 90) begin
        // one bit off a valid pattern
        pat = classifier_scoreboard::fault_pattern($urandom_range(0, 10));
        d   = with_pattern(d, pat ^ (24'd1 << $urandom_range(0, 23)));
      end
      id = {ID_PRIO, PF_DM1, PS_DM1, sb.peer_addr};
    end else if (r < 50) begin
      c = $urandom_range(0, 9);
      if (c < 7) begin
        case ($urandom_range(0, 3))
          0:       d[12:9] = DM15_CODE_PROCEED;
          1:       d[12:9] = DM15_CODE_BUSY;
          2:       d[12:9] = DM15_CODE_COMPLETED;
          default: d[12:9] = DM15_CODE_FAILED;
        endcase
      end
      id = {ID_PRIO, PF_DM15, sb.own_addr, sb.peer_addr};
    end else if (r < 65) begin
      id = {ID_PRIO, PF_DM16, sb.own_addr, sb.peer_addr};
    end else if (r < 72) begin
      mode = MODE_WAIT;
    end else if (r < 79) begin
      mode = MODE_CLEAR;
    end else if (r < 82) begin
      mode = MODE_UNUSED;
    end else if (r < 92) begin
      // well-formed identifier with one field broken
      c  = $urandom_range(0, 2);
      pf = (c == 0) ? PF_DM1 : (c == 1) ? PF_DM15 : PF_DM16;
      ps = (c == 0) ? PS_DM1 : sb.own_addr;
      id = {ID_PRIO, pf, ps, sb.peer_addr};
      case ($urandom_range(0, 2))
        0:       id[28:24] = id[28:24] ^ 5'($urandom_range(1, 31));
        1:       id[15:8]  = id[15:8] ^ 8'($urandom_range(1, 255));
        default: id[7:0]   = id[7:0] ^ 8'($urandom_range(1, 255));
      endcase
    end
    send_request(mode, id, d);
  endtask

  initial begin
    logic [7:0] own;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    calm          = 1'b0;
    cycles        = 0;
    own_writes    = 0;
    sb.clear_state();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part, own address still at its reset value
    send_request(MODE_FRAME, 29'h0, 64'h0);
    send_request(MODE_FRAME, 29'h1FFFFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(MODE_FRAME, {ID_PRIO, PF_CLAIM, PS_GLOBAL, 8'h25}, 64'h0123_4567_89AB_CDEF);
    // no-error fault report
    send_request(MODE_FRAME, {ID_PRIO, PF_DM1, PS_DM1, 8'h25}, 64'h0);
    for (int i = 0; i < 11; i++) begin
      send_request(MODE_FRAME, {ID_PRIO, PF_DM1, PS_DM1, 8'h25},
                   with_pattern(rand64(), classifier_scoreboard::fault_pattern(i)));
    end
    send_request(MODE_WAIT, 29'h1FFFFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(MODE_FRAME, {ID_PRIO, PF_DM15, 8'h00, 8'h25},
                 {48'h0, 8'(DM15_CODE_PROCEED) << 1, 8'h0});
    send_request(MODE_FRAME, {ID_PRIO, PF_DM15, 8'h00, 8'h25},
                 {48'h0, 8'(DM15_CODE_BUSY) << 1, 8'h0});
    send_request(MODE_FRAME, {ID_PRIO, PF_DM15, 8'h00, 8'h25},
                 {48'h0, 8'(DM15_CODE_COMPLETED) << 1, 8'h0});
    send_request(MODE_FRAME, {ID_PRIO, PF_DM15, 8'h00, 8'h25},
                 {48'h0, 8'(DM15_CODE_FAILED) << 1, 8'h0});
    // status code with no meaning leaves the status alone
    send_request(MODE_FRAME, {ID_PRIO, PF_DM15, 8'h00, 8'h25}, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(MODE_FRAME, {ID_PRIO, PF_DM16, 8'h00, 8'h25}, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(MODE_CLEAR, 29'h0, 64'h0);
    send_request(MODE_UNUSED, {ID_PRIO, PF_DM16, 8'h00, 8'h25}, rand64());
    send_request(MODE_FRAME, {ID_PRIO, PF_CLAIM, PS_GLOBAL, SA_NULL}, rand64());
    // old peer address no longer matches after the cannot-claim frame
    send_request(MODE_FRAME, {ID_PRIO, PF_DM1, PS_DM1, 8'h25},
                 with_pattern(64'h0, classifier_scoreboard::fault_pattern(0)));

    for (int p = 0; p < NUM_PHASES; p++) begin
      own = (p == 0) ? 8'hFF : (p == 1) ? 8'h00 : 8'($urandom);
      set_own_address(own);
      calm = (p == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold off once mid-phase until the pipe is empty
        if (p == 2 && n == PHASE_ITEMS / 2) wait_drain();
        random_request();
      end
    end
    calm = 1'b0;

    wait_drain();
    repeat (10) @(posedge clk_i);
    $display("%0d requests sent, %0d results checked over %0d own-address settings",
             sb.requests, sb.checked, own_writes);
    $display("kinds seen: ignored %0d claim %0d noclaim %0d fault %0d status %0d data %0d",
             sb.kind_hits[0], sb.kind_hits[1], sb.kind_hits[2], sb.kind_hits[3],
             sb.kind_hits[4], sb.kind_hits[5]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/dfc_pkg.sv
rtl/dfc_front.sv
rtl/dfc_fifo.sv
rtl/dfc_back.sv
rtl/diagnostic_frame_classifier.sv
rtl/dfc_checker.sv
tb/diagnostic_frame_classifier_test.sv
